>>> hw/rtl/ps2_set1_scancode_to_ascii_defines.svh
// assertion macros shared by the rtl of the scancode decoder
// needs nothing; included by files that carry concurrent assertions
`ifndef PS2_SET1_SCANCODE_TO_ASCII_DEFINES_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define PS2S1_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2s1 check failed");

// next-cycle implication, skipped while reset is high
`define PS2S1_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2s1 check failed");

`endif

>>> hw/rtl/ps2s1_pkg.sv
// types, scancode constants and keymap tables of the scancode decoder
// depends on nothing
`default_nettype none

package ps2s1_pkg;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned KEY_W  = 7;
   localparam int unsigned CHAR_W = 7;

   localparam logic [CODE_W-1:0] PREFIX_CODE  = 8'hE0;
   localparam int unsigned       RELEASE_BIT  = 7;
   localparam logic [KEY_W-1:0]  ALTGR_KEY    = 7'h38;
   localparam logic [KEY_W-1:0]  LSHIFT_KEY   = 7'h2A;
   localparam logic [KEY_W-1:0]  RSHIFT_KEY   = 7'h36;
   localparam logic [CHAR_W-1:0] NO_CHAR      = 7'h00;

   // modifier state handed to the keymap
   typedef struct packed {
      logic shifted;
      logic altgr;
   } mods_type;

   // unshifted us layout
   function automatic logic [CHAR_W-1:0] base_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] ch;
      unique case (key)
         7'h01: ch = 7'h1B;
         7'h02: ch = 7'h31;
         7'h03: ch = 7'h32;
         7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;
         7'h06: ch = 7'h35;
         7'h07: ch = 7'h36;
         7'h08: ch = 7'h37;
         7'h09: ch = 7'h38;
         7'h0A: ch = 7'h39;
         7'h0B: ch = 7'h30;
         7'h0C: ch = 7'h2D;
         7'h0D: ch = 7'h3D;
         7'h0E: ch = 7'h08;
         7'h0F: ch = 7'h09;
         7'h10: ch = 7'h71;
         7'h11: ch = 7'h77;
         7'h12: ch = 7'h65;
         7'h13: ch = 7'h72;
         7'h14: ch = 7'h74;
         7'h15: ch = 7'h79;
         7'h16: ch = 7'h75;
         7'h17: ch = 7'h69;
         7'h18: ch = 7'h6F;
         7'h19: ch = 7'h70;
         7'h1A: ch = 7'h5B;
         7'h1B: ch = 7'h5D;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h61;
         7'h1F: ch = 7'h73;
         7'h20: ch = 7'h64;
         7'h21: ch = 7'h66;
         7'h22: ch = 7'h67;
         7'h23: ch = 7'h68;
         7'h24: ch = 7'h6A;
         7'h25: ch = 7'h6B;
         7'h26: ch = 7'h6C;
         7'h27: ch = 7'h3B;
         7'h28: ch = 7'h27;
         7'h29: ch = 7'h60;
         7'h2B: ch = 7'h5C;
         7'h2C: ch = 7'h7A;
         7'h2D: ch = 7'h78;
         7'h2E: ch = 7'h63;
         7'h2F: ch = 7'h76;
         7'h30: ch = 7'h62;
         7'h31: ch = 7'h6E;
         7'h32: ch = 7'h6D;
         7'h33: ch = 7'h2C;
         7'h34: ch = 7'h2E;
         7'h35: ch = 7'h2F;
         7'h37: ch = 7'h2A;
         7'h39: ch = 7'h20;
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

   // shifted us layout
   function automatic logic [CHAR_W-1:0] shift_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] ch;
      unique case (key)
         7'h01: ch = 7'h1B;
         7'h02: ch = 7'h21;
         7'h03: ch = 7'h40;
         7'h04: ch = 7'h23;
         7'h05: ch = 7'h24;
         7'h06: ch = 7'h25;
         7'h07: ch = 7'h5E;
         7'h08: ch = 7'h26;
         7'h09: ch = 7'h2A;
         7'h0A: ch = 7'h28;
         7'h0B: ch = 7'h29;
         7'h0C: ch = 7'h5F;
         7'h0D: ch = 7'h2B;
         7'h0E: ch = 7'h08;
         7'h0F: ch = 7'h09;
         7'h10: ch = 7'h51;
         7'h11: ch = 7'h57;
         7'h12: ch = 7'h45;
         7'h13: ch = 7'h52;
         7'h14: ch = 7'h54;
         7'h15: ch = 7'h59;
         7'h16: ch = 7'h55;
         7'h17: ch = 7'h49;
         7'h18: ch = 7'h4F;
         7'h19: ch = 7'h50;
         7'h1A: ch = 7'h7B;
         7'h1B: ch = 7'h7D;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h41;
         7'h1F: ch = 7'h53;
         7'h20: ch = 7'h44;
         7'h21: ch = 7'h46;
         7'h22: ch = 7'h47;
         7'h23: ch = 7'h48;
         7'h24: ch = 7'h4A;
         7'h25: ch = 7'h4B;
         7'h26: ch = 7'h4C;
         7'h27: ch = 7'h3A;
         7'h28: ch = 7'h22;
         7'h29: ch = 7'h7E;
         7'h2B: ch = 7'h7C;
         7'h2C: ch = 7'h5A;
         7'h2D: ch = 7'h58;
         7'h2E: ch = 7'h43;
         7'h2F: ch = 7'h56;
         7'h30: ch = 7'h42;
         7'h31: ch = 7'h4E;
         7'h32: ch = 7'h4D;
         7'h33: ch = 7'h3C;
         7'h34: ch = 7'h3E;
         7'h35: ch = 7'h3F;
         7'h37: ch = 7'h2A;
         7'h39: ch = 7'h20;
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

   // altgr overlay, zero means fall through
   function automatic logic [CHAR_W-1:0] altgr_char(input logic [KEY_W-1:0] key);
      logic [CHAR_W-1:0] ch;
      unique case (key)
         7'h03: ch = 7'h40;
         7'h04: ch = 7'h23;
         7'h08: ch = 7'h7B;
         7'h09: ch = 7'h5B;
         7'h0A: ch = 7'h5D;
         7'h0B: ch = 7'h7D;
         7'h10: ch = 7'h40;
         7'h1A: ch = 7'h5B;
         7'h1B: ch = 7'h5D;
         7'h27: ch = 7'h40;
         7'h28: ch = 7'h23;
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

   // altgr plus shift overlay
   function automatic logic [CHAR_W-1:0] altgr_shift_char(
      input logic [KEY_W-1:0] key
   );
      logic [CHAR_W-1:0] ch;
      unique case (key)
         7'h1A: ch = 7'h7B;
         7'h1B: ch = 7'h7D;
         default: ch = NO_CHAR;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ps2s1_if.sv
// request and response channel interfaces of the scancode decoder
// depends on ps2s1_pkg for the field widths
`default_nettype none

interface ps2s1_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2s1_pkg::CODE_W-1:0]   scancode;

   modport source (output valid, output scancode, input ready);
   modport sink   (input valid, input scancode, output ready);
endinterface

interface ps2s1_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ps2s1_pkg::CHAR_W-1:0]   character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ps2_set1_scancode_to_ascii.sv
// top level of the set-1 scancode to ascii decoder
// depends on ps2s1_pkg, ps2s1_if, ps2s1_keymap and the assertion macro header
//
//   channel   dir   payload            meaning
//   req_chan  in    scancode  [7:0]    raw keyboard byte, one per request
//   rsp_chan  out   character [6:0]    ascii of a pressed key, only when nonzero
//
// one request per cycle unless an untaken response stalls; a result appears
// in the response register in the cycle after its request and waits until taken
// the decode and the keymap lookup are one short pass into that register
// a request is taken while the response register is empty or being drained
// synchronous reset clears the modifier flags, the prefix and the response valid
// ready stays low while reset is high
`default_nettype none

`include "ps2_set1_scancode_to_ascii_defines.svh"

module ps2_set1_scancode_to_ascii (
   input wire logic  clock,
   input wire logic  reset,
   ps2s1_req_if.sink req_chan,
   ps2s1_rsp_if.source rsp_chan
);
   import ps2s1_pkg::*;

   // modifier and prefix flags
   logic left_shift_ff,  left_shift_in;
   logic right_shift_ff, right_shift_in;
   logic altgr_ff,       altgr_in;
   logic prefix_ff,      prefix_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff,  rsp_char_in;

   logic              accept;
   logic              key_up;
   logic [KEY_W-1:0]  key;
   logic              is_prefix;
   logic              hit;
   mods_type          mods;
   logic [CHAR_W-1:0] lookup_char;

   // take a request whenever the response slot frees up this cycle
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign key_up     = req_chan.scancode[RELEASE_BIT];
   assign key        = req_chan.scancode[KEY_W-1:0];
   assign is_prefix  = (req_chan.scancode == PREFIX_CODE);

   // either shift counts
   assign mods.shifted = left_shift_ff || right_shift_ff;
   assign mods.altgr   = altgr_ff;

   ps2s1_keymap u_keymap (
      .key       (key),
      .mods      (mods),
      .character (lookup_char)
   );

   // flag updates and press detection for the byte being taken
   always_comb begin
      left_shift_in  = left_shift_ff;
      right_shift_in = right_shift_ff;
      altgr_in       = altgr_ff;
      prefix_in      = prefix_ff;
      hit            = 1'b0;
      if (accept) begin
         priority if (is_prefix) begin
            // repeated prefix just stays armed
            prefix_in = 1'b1;
         end else if (prefix_ff) begin
            // extended key is swallowed, only right alt matters
            prefix_in = 1'b0;
            if (key == ALTGR_KEY) begin
               altgr_in = !key_up;
            end
         end else if (key == LSHIFT_KEY) begin
            left_shift_in = !key_up;
         end else if (key == RSHIFT_KEY) begin
            right_shift_in = !key_up;
         end else if (!key_up) begin
            // unmapped keys give nothing
            hit = (lookup_char != NO_CHAR);
         end
      end
   end

   // response slot: load on a hit, drop once taken
   always_comb begin
      rsp_char_in = rsp_char_ff;
      if (accept) begin
         rsp_valid_in = hit;
         if (hit) begin
            rsp_char_in = lookup_char;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_shift_ff  <= 1'b0;
         right_shift_ff <= 1'b0;
         altgr_ff       <= 1'b0;
         prefix_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         left_shift_ff  <= left_shift_in;
         right_shift_ff <= right_shift_in;
         altgr_ff       <= altgr_in;
         prefix_ff      <= prefix_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;

   // a prefix byte arms the prefix for the next request
   `PS2S1_ASSERT_NEXT(a_prefix_arms, clock, reset, accept && is_prefix, prefix_ff)

   // any other byte after a prefix disarms it and yields nothing
   `PS2S1_ASSERT_NEXT(a_prefix_consumed, clock, reset,
      accept && prefix_ff && !is_prefix, !prefix_ff && !rsp_valid_ff)

   // a release outside the prefix never produces a character
   `PS2S1_ASSERT_NEXT(a_release_silent, clock, reset,
      accept && !prefix_ff && key_up, !rsp_valid_ff)

   // a shown response always carries a real character
   `PS2S1_ASSERT_NOW(a_rsp_nonzero, clock, reset, rsp_valid_ff, rsp_char_ff != NO_CHAR)

endmodule

`default_nettype wire

>>> hw/rtl/ps2s1_keymap.sv
// keymap lookup: picks the character of a key from the layout tables
// depends on ps2s1_pkg
`default_nettype none

module ps2s1_keymap (
   input  wire logic [ps2s1_pkg::KEY_W-1:0]  key,
   input  wire ps2s1_pkg::mods_type          mods,
   output      logic [ps2s1_pkg::CHAR_W-1:0] character
);
   import ps2s1_pkg::*;

   logic [CHAR_W-1:0] ag_shift_ch;
   logic [CHAR_W-1:0] ag_ch;
   logic [CHAR_W-1:0] plain_ch;

   assign ag_shift_ch = altgr_shift_char(key);
   assign ag_ch       = altgr_char(key);
   assign plain_ch    = mods.shifted ? shift_char(key) : base_char(key);

   // first nonzero overlay entry wins
   always_comb begin
      priority if (mods.altgr && mods.shifted && (ag_shift_ch != NO_CHAR)) begin
         character = ag_shift_ch;
      end else if (mods.altgr && (ag_ch != NO_CHAR)) begin
         character = ag_ch;
      end else begin
         character = plain_ch;
      end
   end

endmodule

`default_nettype wire
